// ===== rtl/zcbs_pkg.sv =====
// zcbs_pkg: types, field codes and store sizing for the zero crossing boundary snap
// used by zero_crossing_boundary_snap; depends on nothing else
`timescale 1ns / 1ps

package zcbs_pkg;

   // store sizing
   localparam int MAX_SAMPLES = 65536;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   // index arithmetic width, wide enough for position plus range and for the count
   localparam int WIDE_W      = ((CNT_W > 17) ? CNT_W : 17) + 1;

   localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_SAMPLES);
   localparam logic [15:0]      RANGE_RESET = 16'd100;

   // word kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   // chosen side codes
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [15:0]        position;
   } req_type;

   typedef struct packed {
      logic [15:0] boundary;
      logic [1:0]  chosen_side;
   } rsp_type;

endpackage

// ===== rtl/zero_crossing_boundary_snap.sv =====
// zero_crossing_boundary_snap: sample store and nearest zero crossing search
// depends on zcbs_pkg
`timescale 1ns / 1ps

//  channel | ports                         | word
//  --------+-------------------------------+---------------------------------
//  req     | req_valid req_stall req_data  | kind, sample, position
//  rsp     | rsp_valid rsp_stall rsp_data  | boundary, chosen_side
//  csr     | csr_wr_en csr_wr_data         | search_range
//
//  clear and append words give no result.
//  a query goes through setup states (calc, plan), a downward scan and then an upward
//  scan that read one sign per cycle from the store, and a final hand-off state; its
//  length is set by the single read port of the sign store.
//  reset is synchronous: it empties the store (count to zero), sets search_range to 100.
//  the result sits in an output register; a stalled result holds the next query in its
//  final state, and no clear, append or query words are taken until it moves on.
module zero_crossing_boundary_snap (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  zcbs_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output zcbs_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data
);
   import zcbs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_PLAN,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE
   } state_type;

   // sign store: only the sign bit of each sample is ever examined
   logic sign_mem [MAX_SAMPLES];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       range_ff, range_in;
   logic [15:0]       pos_ff, pos_in;
   logic [WIDE_W-1:0] p_ff, p_in;
   logic [WIDE_W-1:0] lo_m1_ff, lo_m1_in;
   logic [WIDE_W-1:0] hi_ff, hi_in;
   logic              len_ok_ff, len_ok_in;
   logic              left_en_ff, left_en_in;
   logic              right_en_ff, right_en_in;
   logic [WIDE_W-1:0] scan_addr_ff, scan_addr_in;
   logic              issue_ff, issue_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [WIDE_W-1:0] pend_idx_ff, pend_idx_in;
   logic              pend_last_ff, pend_last_in;
   logic              prev_neg_ff, prev_neg_in;
   logic              have_prev_ff, have_prev_in;
   logic              lfound_ff, lfound_in;
   logic              rfound_ff, rfound_in;
   logic [WIDE_W-1:0] lcand_ff, lcand_in;
   logic [WIDE_W-1:0] rcand_ff, rcand_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              mem_q_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic              mem_wd;
   logic [IDX_W-1:0]  mem_ra;
   logic              hit;

   logic [WIDE_W-1:0] len_w, pos_w, rng_w, last_w, pv_w, lo_w, hi_w, dl_w, dr_w;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mem_ra = scan_addr_ff[IDX_W-1:0];
   // crossing seen: previous read was non-negative and this one is negative
   assign hit    = pend_vld_ff && have_prev_ff && !prev_neg_ff && mem_q_ff;

   // query window arithmetic, from the registered position and count
   always_comb begin
      len_w  = WIDE_W'(count_ff);
      pos_w  = WIDE_W'(pos_ff);
      rng_w  = WIDE_W'(range_ff);
      last_w = len_w - WIDE_W'(1);
      pv_w   = (pos_w < last_w) ? pos_w : last_w;
      lo_w   = (pos_w > rng_w) ? (pos_w - rng_w) : '0;
      if (lo_w < WIDE_W'(1)) begin
         lo_w = WIDE_W'(1);
      end
      hi_w = pos_w + rng_w;
      if ((len_w - WIDE_W'(2)) < hi_w) begin
         hi_w = len_w - WIDE_W'(2);
      end
      dl_w = pos_w - lcand_ff;
      dr_w = rcand_ff - pos_w;
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      range_in     = range_ff;
      pos_in       = pos_ff;
      p_in         = p_ff;
      lo_m1_in     = lo_m1_ff;
      hi_in        = hi_ff;
      len_ok_in    = len_ok_ff;
      left_en_in   = left_en_ff;
      right_en_in  = right_en_ff;
      scan_addr_in = scan_addr_ff;
      issue_in     = 1'b0;
      pend_vld_in  = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      prev_neg_in  = prev_neg_ff;
      have_prev_in = have_prev_ff;
      lfound_in    = lfound_ff;
      rfound_in    = rfound_ff;
      lcand_in     = lcand_ff;
      rcand_in     = rcand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[IDX_W-1:0];
      mem_wd       = req_data.sample[15];

      // result register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         range_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_APPEND: begin
                     if (count_ff < MAX_COUNT) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_QUERY: begin
                     pos_in   = req_data.position;
                     state_in = ST_CALC;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CALC: begin
            len_ok_in   = (count_ff >= CNT_W'(2));
            p_in        = pv_w;
            lo_m1_in    = lo_w - WIDE_W'(1);
            hi_in       = hi_w;
            left_en_in  = (pv_w >= lo_w);
            right_en_in = (pv_w < hi_w);
            lfound_in   = 1'b0;
            rfound_in   = 1'b0;
            state_in    = ST_PLAN;
         end

         ST_PLAN: begin
            scan_addr_in = p_ff;
            have_prev_in = 1'b0;
            if (!len_ok_ff) begin
               state_in = ST_DONE;
            end else if (left_en_ff) begin
               issue_in = 1'b1;
               state_in = ST_LEFT;
            end else if (right_en_ff) begin
               issue_in = 1'b1;
               state_in = ST_RIGHT;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_LEFT: begin
            // issue the next read downward, last one at lo - 1
            if (issue_ff) begin
               pend_vld_in  = 1'b1;
               pend_idx_in  = scan_addr_ff;
               pend_last_in = (scan_addr_ff == lo_m1_ff);
               issue_in     = (scan_addr_ff != lo_m1_ff);
               scan_addr_in = scan_addr_ff - WIDE_W'(1);
            end
            // examine the word returned for the read issued last cycle
            if (pend_vld_ff) begin
               prev_neg_in  = mem_q_ff;
               have_prev_in = 1'b1;
               if (hit) begin
                  lfound_in = 1'b1;
                  lcand_in  = pend_idx_ff;
               end
               if (hit || pend_last_ff) begin
                  pend_vld_in  = 1'b0;
                  scan_addr_in = p_ff;
                  have_prev_in = 1'b0;
                  issue_in     = right_en_ff;
                  state_in     = right_en_ff ? ST_RIGHT : ST_DONE;
               end
            end
         end

         ST_RIGHT: begin
            // issue the next read upward, last one at hi
            if (issue_ff) begin
               pend_vld_in  = 1'b1;
               pend_idx_in  = scan_addr_ff;
               pend_last_in = (scan_addr_ff == hi_ff);
               issue_in     = (scan_addr_ff != hi_ff);
               scan_addr_in = scan_addr_ff + WIDE_W'(1);
            end
            if (pend_vld_ff) begin
               prev_neg_in  = mem_q_ff;
               have_prev_in = 1'b1;
               if (hit) begin
                  rfound_in = 1'b1;
                  rcand_in  = pend_idx_ff;
               end
               if (hit || pend_last_ff) begin
                  pend_vld_in = 1'b0;
                  issue_in    = 1'b0;
                  state_in    = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // pick the nearer crossing, the right one on a tie
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.boundary     = pos_ff;
               rsp_data_in.chosen_side  = SIDE_NONE;
               if (lfound_ff && (!rfound_ff || (dl_w < dr_w))) begin
                  rsp_data_in.boundary    = lcand_ff[15:0];
                  rsp_data_in.chosen_side = SIDE_LEFT;
               end else if (rfound_ff) begin
                  rsp_data_in.boundary    = rcand_ff[15:0];
                  rsp_data_in.chosen_side = SIDE_RIGHT;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sign store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sign_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= sign_mem[mem_ra];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         range_ff     <= RANGE_RESET;
         issue_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         range_ff     <= range_in;
         issue_ff     <= issue_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      p_ff         <= p_in;
      lo_m1_ff     <= lo_m1_in;
      hi_ff        <= hi_in;
      len_ok_ff    <= len_ok_in;
      left_en_ff   <= left_en_in;
      right_en_ff  <= right_en_in;
      scan_addr_ff <= scan_addr_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      prev_neg_ff  <= prev_neg_in;
      have_prev_ff <= have_prev_in;
      lfound_ff    <= lfound_in;
      rfound_ff    <= rfound_in;
      lcand_ff     <= lcand_in;
      rcand_ff     <= rcand_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("sample count above store depth");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == ST_IDLE) || $past(reset))
      else $error("sample count changed during a query");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == ST_LEFT) || (state_ff == ST_RIGHT))
      else $error("store read in flight outside a scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the final state");

endmodule
